// File: src/palette_linear_fade_unit_assert.svh
// Assertion macros used by the checker of the palette fade unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PALETTE_LINEAR_FADE_UNIT_ASSERT_SVH
`define PALETTE_LINEAR_FADE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette fade check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette fade check failed");

`endif

// File: src/plf_pkg.sv
package plf_pkg;

    // Item commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_FADE_FRAMES = 2'd0;
    localparam cfg_index_t REG_FIRST_ENTRY = 2'd1;
    localparam cfg_index_t REG_END_ENTRY   = 2'd2;

    localparam logic [7:0] FADE_FRAMES_RESET = 8'd10;
    localparam logic [5:0] FIRST_ENTRY_RESET = 6'd1;
    localparam logic [6:0] END_ENTRY_RESET   = 7'd64;

    // A frame step reports at most this many entries.
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;
        logic div_step;
        logic load_write;
        logic run_start;
        logic rd_issue;
        logic upd;
    } plf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_ok;
        logic run_empty;
        logic run_last;
    } plf_stat_t;

endpackage

// File: src/plf_datapath.sv
module plf_datapath #(
    parameter int ENTRIES       = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  plf_pkg::plf_cmd_t  cmd,
    output plf_pkg::plf_stat_t stat,
    input  logic [5:0]         entry_index,
    input  logic [23:0]        source_colour,
    input  logic [23:0]        target_colour,
    input  logic               cfg_write,
    input  plf_pkg::cfg_index_t cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               out_valid,
    output logic [5:0]         out_index,
    output logic [23:0]        out_colour,
    output logic               last
);
    import plf_pkg::*;

    localparam int W  = FRACTION_BITS + 9;
    localparam int DW = FRACTION_BITS + 8;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [8:0] ENTRIES_W = 9'(ENTRIES);
    localparam logic [W-1:0] ACC_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ACC_MIN = {1'b1, {(W-1){1'b0}}};

    // Configuration registers.
    logic [7:0] fade_frames_reg;
    logic [5:0] first_entry_reg;
    logic [6:0] end_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_frames_reg <= FADE_FRAMES_RESET;
            first_entry_reg <= FIRST_ENTRY_RESET;
            end_entry_reg   <= END_ENTRY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FADE_FRAMES: fade_frames_reg <= cfg_data;
                REG_FIRST_ENTRY: first_entry_reg <= cfg_data[5:0];
                REG_END_ENTRY:   end_entry_reg   <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    // Load side: three restoring dividers, one quotient bit per cycle.
    logic [AW-1:0]          ld_idx_reg;
    logic [23:0]            src_reg;
    logic [7:0]             div_reg;
    logic [2:0]             neg_reg;
    logic [2:0][DW-1:0]     quo_reg;
    logic [2:0][7:0]        rem_reg;
    logic [2:0][DW-1:0]     quo_next;
    logic [2:0][7:0]        rem_next;
    logic [2:0][DW-1:0]     dividend;
    logic [2:0]             neg_in;
    logic [2:0][W-1:0]      ld_step;
    logic [2:0][W-1:0]      ld_cur;

    always_comb
    begin
        logic [8:0] trial;
        logic [7:0] s_ch;
        logic [7:0] d_ch;
        for (int c = 0; c < 3; c++)
        begin
            s_ch = source_colour[8*c +: 8];
            d_ch = target_colour[8*c +: 8];
            neg_in[c]   = d_ch < s_ch;
            dividend[c] = {(neg_in[c] ? s_ch - d_ch : d_ch - s_ch), {FRACTION_BITS{1'b0}}};
            trial = {rem_reg[c], quo_reg[c][DW-1]};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next[c] = 8'(trial - {1'b0, div_reg});
                quo_next[c] = {quo_reg[c][DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[7:0];
                quo_next[c] = {quo_reg[c][DW-2:0], 1'b0};
            end
            ld_step[c] = neg_reg[c] ? W'(-{1'b0, quo_reg[c]}) : {1'b0, quo_reg[c]};
            ld_cur[c]  = {1'b0, src_reg[8*c +: 8], {FRACTION_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            ld_idx_reg <= AW'(entry_index);
            src_reg    <= source_colour;
            div_reg    <= (fade_frames_reg == 8'd0) ? 8'd1 : fade_frames_reg;
            neg_reg    <= neg_in;
            quo_reg    <= dividend;
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Frame step run counters.
    logic [8:0]       e_reg;
    logic [8:0]       stop_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [8:0]       stop_comb;
    logic [8:0]       e_inc;

    assign stop_comb = ({2'b00, end_entry_reg} > ENTRIES_W) ? ENTRIES_W
                                                            : {2'b00, end_entry_reg};
    assign e_inc = e_reg + 9'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.run_start)
        begin
            e_reg    <= {3'b000, first_entry_reg};
            stop_reg <= stop_comb;
            cnt_reg  <= '0;
        end
        else if (cmd.upd)
        begin
            e_reg   <= e_inc;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign stat.idx_ok    = {3'b000, entry_index} < ENTRIES_W;
    assign stat.run_empty = {3'b000, first_entry_reg} >= stop_comb;
    assign stat.run_last  = (e_inc >= stop_reg) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    // Palette store: current values in the low half, steps in the high half.
    logic [6*W-1:0]   mem [ENTRIES];
    logic [6*W-1:0]   rd_data_reg;
    logic             rd_valid_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [6*W-1:0]   rd_word;
    logic [6*W-1:0]   wr_word;
    logic [AW-1:0]    wr_addr;
    logic [2:0][W-1:0] new_cur;
    logic [2:0][7:0]   new_ch;

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        logic [W:0]   sum;
        logic [W-1:0] cur;
        logic [W-1:0] stp;
        for (int c = 0; c < 3; c++)
        begin
            cur = rd_word[c*W +: W];
            stp = rd_word[(3+c)*W +: W];
            sum = {cur[W-1], cur} + {stp[W-1], stp};
            if (sum[W] != sum[W-1])
            begin
                new_cur[c] = sum[W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                new_cur[c] = sum[W-1:0];
            end
            new_ch[c] = new_cur[c][W-1] ? 8'd0 : new_cur[c][FRACTION_BITS +: 8];
        end
    end

    always_comb
    begin
        if (cmd.load_write)
        begin
            wr_addr = ld_idx_reg;
            wr_word = {ld_step[2], ld_step[1], ld_step[0], ld_cur[2], ld_cur[1], ld_cur[0]};
        end
        else
        begin
            wr_addr = AW'(e_reg);
            wr_word = {rd_word[6*W-1:3*W], new_cur[2], new_cur[1], new_cur[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write || cmd.upd)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[AW'(e_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_write || cmd.upd)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_issue)
            begin
                rd_valid_reg <= valid_reg[AW'(e_reg)];
            end
        end
    end

    // Result register.
    logic        out_valid_reg;
    logic [5:0]  out_index_reg;
    logic [23:0] out_colour_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            out_index_reg  <= e_reg[5:0];
            out_colour_reg <= {new_ch[2], new_ch[1], new_ch[0]};
            last_reg       <= stat.run_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_colour = out_colour_reg;
    assign last       = last_reg;

endmodule

// File: src/plf_ctrl.sv
module plf_ctrl #(
    parameter int DIV_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               command,
    input  plf_pkg::plf_stat_t stat,
    output plf_pkg::plf_cmd_t  cmd,
    output logic               busy
);
    import plf_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV     = 3'd1;
    localparam logic [2:0] S_LOAD_WR = 3'd2;
    localparam logic [2:0] S_RUN_RD  = 3'd3;
    localparam logic [2:0] S_RUN_UPD = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] div_cnt_reg;
    logic [CW-1:0] div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_LOAD)
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.load_start = 1'b1;
                            div_cnt_next   = '0;
                            state_next     = S_DIV;
                        end
                    end
                    else if (!stat.run_empty)
                    begin
                        cmd.run_start = 1'b1;
                        state_next    = S_RUN_RD;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + CW'(1);
                if (div_cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_LOAD_WR;
                end
            end
            S_LOAD_WR:
            begin
                cmd.load_write = 1'b1;
                state_next     = S_IDLE;
            end
            S_RUN_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RUN_UPD;
            end
            S_RUN_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = stat.run_last ? S_IDLE : S_RUN_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

// File: src/palette_linear_fade_unit.sv
// Palette fader for ENTRIES RGB888 entries. An item is accepted on a clock
// edge with start high and busy low. A load item (command 0) keeps busy high
// while three restoring dividers, one per channel, produce one quotient bit
// per cycle; then a write state stores the entry. A frame-step item
// (command 1) walks the entries from first_entry up to but not including
// end_entry (clamped to ENTRIES), at most 64 of them, reading each one from
// the palette memory in a read state and writing it back in an update state.
// Each updated colour appears on out_index and out_colour for exactly one
// cycle with out_valid high, the first one after the read state, the update
// state and the result register; the receiver cannot stall these results
// and must take each one as it comes. The last result of a run has last set
// and coincides with busy falling. A load names no result, nor does a frame
// step whose range is empty. The palette starts at zero after reset without
// a clearing pass. The user writes configuration through cfg_write, cfg_index
// and cfg_data only while the block is idle; the block does not enforce this.
module palette_linear_fade_unit #(
    parameter int ENTRIES       = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [5:0]          entry_index,
    input  logic [23:0]         source_colour,
    input  logic [23:0]         target_colour,
    input  logic                cfg_write,
    input  plf_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data,
    output logic                out_valid,
    output logic [5:0]          out_index,
    output logic [23:0]         out_colour,
    output logic                last
);
    import plf_pkg::*;

    // The controller sequences loads and frame-step runs; the datapath holds
    // the configuration, the dividers, the palette memory and the result
    // register.
    plf_cmd_t  cmd;
    plf_stat_t stat;

    plf_ctrl #(
        .DIV_STEPS (FRACTION_BITS + 8)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    plf_datapath #(
        .ENTRIES       (ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .entry_index   (entry_index),
        .source_colour (source_colour),
        .target_colour (target_colour),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_index     (out_index),
        .out_colour    (out_colour),
        .last          (last)
    );

endmodule

// File: src/plf_checker.sv
`include "palette_linear_fade_unit_assert.svh"

module plf_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic out_valid,
    input logic last
);
    // An idle block produces no result in the next cycle.
    `PLF_ASSERT_NEXT(a_idle_no_result, !busy, !out_valid)
    // A result that is not the last one leaves the run going.
    `PLF_ASSERT_NOW(a_mid_run_busy, out_valid && !last, busy)
    // The last result of a run arrives as the block goes idle.
    `PLF_ASSERT_NOW(a_last_ends_run, out_valid && last, !busy)

endmodule

bind palette_linear_fade_unit plf_checker u_plf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .out_valid (out_valid),
    .last      (last)
);

// File: dv/palette_linear_fade_unit_test.sv
module palette_linear_fade_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plf_pkg::*;

    // Palette geometry and fixed-point format used by the local prediction.
    localparam int PALETTE_SIZE = 64;
    localparam int FRAC_BITS    = 16;

    // A load keeps the block busy but produces no item on the result side, so
    // before a register write we wait longer than a load lasts even after every
    // expected color has arrived.
    localparam int LOAD_SETTLE_CYCLES = FRAC_BITS + 14;

    // A full frame step walks 64 entries, each read and then written back, and
    // this drain wait outlasts such a run.
    localparam int RUN_DRAIN_CYCLES = 2 * MAX_RESULTS + 20;

    // The longest legal quiet stretch is a long sender gap on top of a load or
    // a register-write pause; this is several times that.
    localparam int QUIET_LIMIT = 2000;

    // Register index 3 is not decoded by the block; writes there are ignored.
    localparam cfg_index_t REG_UNUSED = 2'd3;

    typedef logic signed [FRAC_BITS + 8:0] fix_t;
    typedef logic signed [FRAC_BITS + 9:0] fix_sum_t;

    // Saturation bounds of the per-channel accumulator.
    localparam fix_sum_t SAT_HIGH = fix_sum_t'((1 << (FRAC_BITS + 8)) - 1);
    localparam fix_sum_t SAT_LOW  = fix_sum_t'(-(1 << (FRAC_BITS + 8)));

    // One reported palette color.
    typedef struct packed {
        logic [5:0]  index;
        logic [23:0] color;
        logic        last;
    } shade_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                command = CMD_LOAD;
    logic [5:0]          entry_index = '0;
    logic [23:0]         source_colour = '0;
    logic [23:0]         target_colour = '0;
    logic                cfg_write = 1'b0;
    cfg_index_t          cfg_index = REG_FADE_FRAMES;
    logic [7:0]          cfg_data = '0;
    logic                out_valid;
    logic [5:0]          out_index;
    logic [23:0]         out_colour;
    logic                last;

    palette_linear_fade_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .entry_index   (entry_index),
        .source_colour (source_colour),
        .target_colour (target_colour),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_index     (out_index),
        .out_colour    (out_colour),
        .last          (last)
    );

    always #4 clk = ~clk;

    // Local copy of the palette: the current level and the per-frame slope of
    // each channel (0 red, 1 green, 2 blue) of every entry.
    fix_t level_q [PALETTE_SIZE][3];
    fix_t slope_q [PALETTE_SIZE][3];

    // Local copy of the configuration registers.
    logic [7:0] frames_reg;
    logic [5:0] first_reg;
    logic [6:0] stop_reg;

    // Colors still owed by the block, oldest first.
    shade_t expected_shades[$];

    int idle_pct = 0;
    int fail_count = 0;
    int item_count = 0;
    int load_count = 0;
    int step_count = 0;
    int result_count = 0;
    int write_count = 0;

    // Puts the predicted palette and registers into their post-reset state.
    function automatic void reset_palette_model();
        frames_reg = FADE_FRAMES_RESET;
        first_reg  = FIRST_ENTRY_RESET;
        stop_reg   = END_ENTRY_RESET;
        for (int e = 0; e < PALETTE_SIZE; e++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                level_q[e][c] = '0;
                slope_q[e][c] = '0;
            end
        end
    endfunction

    // A load sets each channel's level to the source and its slope to the
    // scaled difference divided by the frame count, truncated toward zero.
    // A frame count of zero divides as if it were one.
    function automatic void predict_fade_load(logic [5:0] idx, logic [23:0] src,
                                              logic [23:0] dst);
        int frames;
        int diff;
        frames = (frames_reg == 0) ? 1 : int'(frames_reg);
        for (int c = 0; c < 3; c++)
        begin
            diff = int'(dst[23 - 8 * c -: 8]) - int'(src[23 - 8 * c -: 8]);
            slope_q[idx][c] = fix_t'((diff * (1 << FRAC_BITS)) / frames);
            level_q[idx][c] = fix_t'(int'(src[23 - 8 * c -: 8]) * (1 << FRAC_BITS));
        end
    endfunction

    // A frame step advances every entry in the configured range, saturating
    // the accumulator, and queues the clamped color of each one.
    function automatic void predict_frame_step();
        int       stop_at;
        int       n;
        fix_sum_t sum;
        logic [8:0] whole;
        logic [7:0] chan [3];
        shade_t   shade;
        stop_at = (stop_reg > PALETTE_SIZE) ? PALETTE_SIZE : int'(stop_reg);
        n = 0;
        for (int e = int'(first_reg); e < stop_at && n < MAX_RESULTS; e++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum = level_q[e][c] + slope_q[e][c];
                if (sum > SAT_HIGH)
                    sum = SAT_HIGH;
                else if (sum < SAT_LOW)
                    sum = SAT_LOW;
                level_q[e][c] = sum[FRAC_BITS + 8:0];
                whole = sum[FRAC_BITS + 8:FRAC_BITS];
                if (sum < 0)
                    chan[c] = 8'h00;
                else if (whole > 9'd255)
                    chan[c] = 8'hFF;
                else
                    chan[c] = whole[7:0];
            end
            shade.index = e[5:0];
            shade.color = {chan[0], chan[1], chan[2]};
            shade.last  = 1'b0;
            expected_shades.push_back(shade);
            n++;
        end
        if (n > 0)
            expected_shades[expected_shades.size() - 1].last = 1'b1;
    endfunction

    // Presents one item and holds it until the block takes it. The start line
    // is left high after acceptance: the next call either presents the next
    // item right away or lowers start for a gap, so start gets exactly one
    // assignment per edge and is never seen high on a stale item while busy
    // is low.
    task automatic send_item(logic cmd, logic [5:0] idx, logic [23:0] src,
                             logic [23:0] dst);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            // Mostly short gaps, sometimes one long enough to cover a whole
            // load or a long run, so gaps land on every phase of the work.
            if ($urandom_range(3) == 0)
                gap = $urandom_range(1, 160);
            else
                gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        command       <= cmd;
        entry_index   <= idx;
        source_colour <= src;
        target_colour <= dst;
        do
            @(posedge clk);
        while (busy);
        item_count++;
        if (cmd == CMD_LOAD)
        begin
            predict_fade_load(idx, src, dst);
            load_count++;
        end
        else
        begin
            predict_frame_step();
            step_count++;
        end
    endtask

    // Brings the block to rest: all owed colors in, the last load finished,
    // and busy low.
    task automatic settle();
        start <= 1'b0;
        while (expected_shades.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Writes one configuration register while the block is idle.
    task automatic write_reg(cfg_index_t idx, logic [7:0] value);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FADE_FRAMES: frames_reg = value;
            REG_FIRST_ENTRY: first_reg  = value[5:0];
            REG_END_ENTRY:   stop_reg   = value[6:0];
            default:         ;
        endcase
        write_count++;
        @(posedge clk);
    endtask

    task automatic set_fade_config(logic [7:0] frames, logic [5:0] first,
                                   logic [6:0] stop_at);
        write_reg(REG_FADE_FRAMES, frames);
        write_reg(REG_FIRST_ENTRY, {2'b00, first});
        write_reg(REG_END_ENTRY, {1'b0, stop_at});
    endtask

    function automatic logic [23:0] random_color();
        case ($urandom_range(7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                             {8{$urandom_range(1) == 1}}};
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly picks an entry that the current range will step, so that loads
    // show up in the results.
    function automatic logic [5:0] pick_entry();
        int stop_at;
        stop_at = (stop_reg > PALETTE_SIZE) ? PALETTE_SIZE : int'(stop_reg);
        if (int'(first_reg) < stop_at && $urandom_range(3) != 0)
            return 6'($urandom_range(int'(first_reg), stop_at - 1));
        return 6'($urandom_range(PALETTE_SIZE - 1));
    endfunction

    // Picks a new setting; small frame counts dominate so fades complete,
    // with the extremes mixed in.
    task automatic randomize_config();
        logic [7:0] frames;
        logic [5:0] first;
        logic [6:0] stop_at;
        case ($urandom_range(5))
            0:       frames = 8'd0;
            1:       frames = 8'd1;
            2:       frames = 8'd255;
            default: frames = 8'($urandom_range(2, 12));
        endcase
        if ($urandom_range(3) == 0)
            first = 6'($urandom_range(63));
        else
            first = 6'($urandom_range(8));
        case ($urandom_range(3))
            0:       stop_at = 7'($urandom_range(65, 127));
            1:       stop_at = 7'($urandom_range(63));
            default: stop_at = 7'd64;
        endcase
        set_fade_config(frames, first, stop_at);
    endtask

    // Right after reset: the palette is all zero and the reset registers
    // apply (ten frames, entries 1 to 63).
    task automatic test_reset_state();
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        send_item(CMD_LOAD, 6'd5, 24'h000000, 24'h0A1400);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
    endtask

    // One-frame fades overshoot on the second and third steps: the
    // accumulator saturates high on rising channels and goes negative, then
    // saturates low, on falling ones.
    task automatic test_saturation();
        set_fade_config(8'd1, 6'd0, 7'd64);
        send_item(CMD_LOAD, 6'd0, 24'h000000, 24'hFFFFFF);
        send_item(CMD_LOAD, 6'd63, 24'hFFFFFF, 24'h000000);
        send_item(CMD_LOAD, 6'd31, 24'h80FF00, 24'h00FF80);
        send_item(CMD_LOAD, 6'd32, 24'h7F807F, 24'h807F80);
        repeat (3) send_item(CMD_STEP, 6'd63, 24'hFFFFFF, 24'hFFFFFF);
    endtask

    // A frame count of zero behaves like one; 255 gives the finest slope.
    task automatic test_frame_count_extremes();
        set_fade_config(8'd0, 6'd7, 7'd8);
        send_item(CMD_LOAD, 6'd7, 24'h102030, 24'h000000);
        repeat (2) send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        set_fade_config(8'd255, 6'd7, 7'd8);
        send_item(CMD_LOAD, 6'd7, 24'h000000, 24'h010101);
        repeat (2) send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
    endtask

    // Empty ranges, an end past the palette, a single last entry, a write to
    // the undecoded index and a first_entry write with its upper bits set.
    task automatic test_range_edges();
        set_fade_config(8'd4, 6'd9, 7'd9);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        set_fade_config(8'd4, 6'd40, 7'd3);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        set_fade_config(8'd4, 6'd60, 7'd127);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        write_reg(REG_UNUSED, 8'hA5);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        write_reg(REG_FIRST_ENTRY, 8'hFF);
        write_reg(REG_END_ENTRY, 8'd64);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
        write_reg(REG_FIRST_ENTRY, 8'd0);
        write_reg(REG_END_ENTRY, 8'd0);
        send_item(CMD_STEP, 6'd0, 24'h0, 24'h0);
    endtask

    // Random traffic in segments of about thirty items, each under a fresh
    // setting. Most of it is well-formed fades (a few loads followed by a
    // few steps); the rest is noise with every field random.
    task automatic test_random_fades(int pct, int n_items);
        int sent;
        int segment;
        int n_load;
        int n_step;
        idle_pct = pct;
        sent = 0;
        while (sent < n_items)
        begin
            randomize_config();
            segment = 0;
            while (segment < 30 && sent < n_items)
            begin
                if ($urandom_range(99) < 15)
                begin
                    send_item(1'($urandom_range(1)), 6'($urandom), 24'($urandom),
                              24'($urandom));
                    segment++;
                    sent++;
                end
                else
                begin
                    n_load = $urandom_range(1, 6);
                    n_step = (frames_reg < 6) ? $urandom_range(1, frames_reg + 2)
                                              : $urandom_range(1, 8);
                    repeat (n_load)
                        send_item(CMD_LOAD, pick_entry(), random_color(), random_color());
                    repeat (n_step)
                        send_item(CMD_STEP, 6'($urandom), 24'($urandom), 24'($urandom));
                    segment += n_load + n_step;
                    sent += n_load + n_step;
                end
            end
        end
    endtask

    // Every strobed result is matched against the oldest owed color. Sampling
    // at the edge sees the values of the cycle that the edge ends.
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n && out_valid)
        begin
            result_count++;
            if (expected_shades.size() == 0)
            begin
                $error("unexpected result: out_index %0d out_colour %06h last %0b",
                       out_index, out_colour, last);
                fail_count++;
            end
            else
            begin
                want = expected_shades.pop_front();
                if (out_index !== want.index)
                begin
                    $error("out_index: expected %0d, actual %0d", want.index, out_index);
                    fail_count++;
                end
                if (out_colour !== want.color)
                begin
                    $error("out_colour: expected %06h, actual %06h", want.color, out_colour);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if nothing is accepted on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || out_valid || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        reset_palette_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 38;
        test_reset_state();
        test_saturation();
        test_frame_count_extremes();
        test_range_edges();

        test_random_fades(38, 117);
        test_random_fades(48, 117);
        test_random_fades(0, 117);

        // Let the last run finish and make sure nothing extra shows up.
        settle();
        repeat (RUN_DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d fade loads and %0d frame steps, %0d colors checked.",
                 item_count, load_count, step_count, result_count);
        $display("Used %0d register writes, including zero and full frame counts and empty,",
                 write_count);
        $display("clamped and single-entry ranges, with and without sender gaps.");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
